>>> design/ffams_pkg.sv
// Shared types and codes for the first-fit allocator with mark and sweep.
`default_nettype none
package ffams_pkg;

    localparam int HEAP_WORDS_DEF   = 1024;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_MARK  = 2'd2;
    localparam logic [1:0] MODE_SWEEP = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_SIZE = 3'd1;
    localparam logic [2:0] STAT_NO_FIT   = 3'd2;
    localparam logic [2:0] STAT_NO_BLOCK = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_PR,
        ST_SPL,
        ST_FL,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  granted_address;
        logic [10:0] granted_size;
        logic [6:0]  reclaimed_count;
    } result_t;

endpackage
`default_nettype wire

>>> design/ffams_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffams_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/ffams_walk.sv
// Sequencer that walks the segment table once per request and rewrites it.
`default_nettype none
module ffams_walk import ffams_pkg::*; #(
    parameter int HEAP_WORDS   = HEAP_WORDS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int AW   = $clog2(HEAP_WORDS),
    localparam int SZW  = $clog2(HEAP_WORDS + 1),
    localparam int IW   = $clog2(MAX_SEGMENTS),
    localparam int EW   = AW + SZW + 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [1:0]    mode,
    input  wire logic [10:0]   request_size,
    input  wire logic [9:0]    block_address,
    output logic               idle,
    output logic               done,
    input  wire logic          ack,
    output result_t            result,
    output logic               sel,
    output logic [IW-1:0]      rd_addr,
    input  wire logic [EW-1:0] rd_data_a,
    input  wire logic [EW-1:0] rd_data_b,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output logic [EW-1:0]      wr_data
);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int CW   = (SZW > 11) ? SZW : 11;
    localparam int BW   = (AW > 10) ? AW : 10;

    walk_state_t state_reg, state_next;

    logic [1:0]      mode_reg;
    logic [10:0]     req_reg;
    logic [9:0]      addr_reg;
    logic [2:0]      status_reg, status_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   gaddr_reg, gaddr_next;
    logic [SZW-1:0]  gsize_reg, gsize_next;
    logic [CNTW-1:0] rc_reg, rc_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] wp_reg, wp_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            sel_reg, sel_next;
    logic            fresh_reg, fresh_next;
    logic            pend_v_reg, pend_v_next;
    logic [EW-1:0]   pend_reg, pend_next;
    logic [EW-1:0]   rem_reg, rem_next;

    logic [EW-1:0]   ent, item, x;
    logic            split;

    always_comb begin
        ent = sel_reg ? rd_data_b : rd_data_a;
        if (fresh_reg && !sel_reg && idx_reg == '0) begin
            ent = {AW'(0), SZW'(HEAP_WORDS), 1'b1, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= CNTW'(1);
            sel_reg    <= 1'b0;
            fresh_reg  <= 1'b1;
            pend_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
            fresh_reg  <= fresh_next;
            pend_v_reg <= pend_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == ST_IDLE) begin
            mode_reg <= mode;
            req_reg  <= request_size;
            addr_reg <= block_address;
        end
        status_reg <= status_next;
        found_reg  <= found_next;
        gaddr_reg  <= gaddr_next;
        gsize_reg  <= gsize_next;
        rc_reg     <= rc_next;
        idx_reg    <= idx_next;
        wp_reg     <= wp_next;
        pend_reg   <= pend_next;
        rem_reg    <= rem_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_RD;
            ST_RD:   state_next = ST_PR;
            ST_PR: begin
                if (split) begin
                    state_next = ST_SPL;
                end else if (idx_reg + CNTW'(1) < count_reg) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_FL;
                end
            end
            ST_SPL: begin
                if (idx_reg + CNTW'(1) < count_reg) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_FL;
                end
            end
            ST_FL:   state_next = ST_DONE;
            ST_DONE: if (ack) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        status_next = status_reg;
        found_next  = found_reg;
        gaddr_next  = gaddr_reg;
        gsize_next  = gsize_reg;
        rc_next     = rc_reg;
        idx_next    = idx_reg;
        wp_next     = wp_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        fresh_next  = fresh_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        rem_next    = rem_reg;
        wr_en       = 1'b0;
        wr_addr     = wp_reg[IW-1:0];
        wr_data     = pend_reg;
        split       = 1'b0;
        x           = ent;
        item        = ent;

        unique case (mode_reg)
            MODE_ALLOC: begin
                if (!found_reg && ent[1] && CW'(ent[EW-AW-1 -: SZW]) >= CW'(req_reg)) begin
                    if (CW'(ent[EW-AW-1 -: SZW]) == CW'(req_reg)) begin
                        x[1:0] = 2'b00;
                    end else if (count_reg >= CNTW'(MAX_SEGMENTS)) begin
                        x = ent;
                    end else begin
                        x[EW-AW-1 -: SZW] = SZW'(req_reg);
                        x[1:0]            = 2'b00;
                        split             = 1'b1;
                    end
                end
            end
            MODE_FREE: begin
                if (!found_reg && !ent[1] && BW'(ent[EW-1 -: AW]) == BW'(addr_reg)) begin
                    x[1:0] = 2'b10;
                end
            end
            MODE_MARK: begin
                if (!found_reg && !ent[1] && BW'(ent[EW-1 -: AW]) == BW'(addr_reg)) begin
                    x[0] = 1'b1;
                end
            end
            MODE_SWEEP: begin
                x[0] = 1'b0;
                if (!ent[1] && !ent[0]) begin
                    x[1] = 1'b1;
                end
            end
            default: x = ent;
        endcase

        if (state_reg == ST_SPL) begin
            item = rem_reg;
        end else begin
            item = x;
        end

        unique case (state_reg)
            ST_IDLE: begin
                idx_next    = '0;
                wp_next     = '0;
                rc_next     = '0;
                pend_v_next = 1'b0;
                gaddr_next  = '0;
                gsize_next  = '0;
                found_next  = 1'b0;
                unique case (mode)
                    MODE_ALLOC: begin
                        if (request_size == 11'd0) begin
                            status_next = STAT_BAD_SIZE;
                            found_next  = 1'b1;
                        end else begin
                            status_next = STAT_NO_FIT;
                        end
                    end
                    MODE_FREE, MODE_MARK: status_next = STAT_NO_BLOCK;
                    default: status_next = STAT_OK;
                endcase
            end
            ST_PR, ST_SPL: begin
                if (state_reg == ST_PR) begin
                    unique case (mode_reg)
                        MODE_ALLOC: begin
                            if (!found_reg && ent[1]
                                && CW'(ent[EW-AW-1 -: SZW]) >= CW'(req_reg)) begin
                                found_next = 1'b1;
                                if (CW'(ent[EW-AW-1 -: SZW]) != CW'(req_reg)
                                    && count_reg >= CNTW'(MAX_SEGMENTS)) begin
                                    status_next = STAT_FULL;
                                end else begin
                                    status_next = STAT_OK;
                                    gaddr_next  = ent[EW-1 -: AW];
                                    gsize_next  = x[EW-AW-1 -: SZW];
                                end
                            end
                        end
                        MODE_FREE, MODE_MARK: begin
                            if (!found_reg && !ent[1]
                                && BW'(ent[EW-1 -: AW]) == BW'(addr_reg)) begin
                                found_next  = 1'b1;
                                status_next = STAT_OK;
                            end
                        end
                        default: begin
                            if (!ent[1] && !ent[0]) begin
                                rc_next = rc_reg + CNTW'(1);
                            end
                        end
                    endcase
                    rem_next = {AW'(ent[EW-1 -: AW] + AW'(req_reg)),
                                SZW'(ent[EW-AW-1 -: SZW] - SZW'(req_reg)), 1'b1, 1'b0};
                end
                if (state_reg == ST_SPL || !split) begin
                    idx_next = idx_reg + CNTW'(1);
                end
                if (pend_v_reg && pend_reg[1] && item[1]) begin
                    pend_next[EW-AW-1 -: SZW] = pend_reg[EW-AW-1 -: SZW]
                                                + item[EW-AW-1 -: SZW];
                end else begin
                    if (pend_v_reg) begin
                        wr_en   = 1'b1;
                        wp_next = wp_reg + CNTW'(1);
                    end
                    pend_next   = item;
                    pend_v_next = 1'b1;
                end
            end
            ST_FL: begin
                if (pend_v_reg) begin
                    wr_en = 1'b1;
                end
                pend_v_next = 1'b0;
                if (status_reg == STAT_OK) begin
                    count_next = wp_reg + CNTW'(pend_v_reg);
                    sel_next   = !sel_reg;
                    fresh_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign idle    = (state_reg == ST_IDLE);
    assign done    = (state_reg == ST_DONE);
    assign sel     = sel_reg;
    assign rd_addr = idx_reg[IW-1:0];

    always_comb begin
        result.status          = status_reg;
        result.granted_address = 10'(gaddr_reg);
        result.granted_size    = 11'(gsize_reg);
        result.reclaimed_count = (rc_reg > CNTW'(127)) ? 7'd127 : 7'(rc_reg);
    end

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_PR || state_reg == ST_SPL || state_reg == ST_FL))
        else $error("table write outside a walk");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNTW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    a_flip_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FL) |=> (sel_reg == $past(sel_reg)))
        else $error("table flipped outside the flush step");
endmodule
`default_nettype wire

>>> design/first_fit_allocator_mark_sweep_top.sv
// Top level of the first-fit heap allocator with coalescing and mark/sweep.
// Each request walks the whole segment table once, with a RAM read step and
// a process step per segment and an extra step for a split, then a flush
// step and a hand-over step. The hand-over step waits for as long as the
// output register still holds a result that has not been taken. The table
// is held in two RAMs used alternately: the walk reads one and writes the
// rewritten table into the other, which becomes current only when the
// request succeeds. No clearing pass is needed after reset. A finished
// result waits in an output register while the next request is taken.
`default_nettype none
module first_fit_allocator_mark_sweep_top import ffams_pkg::*; #(
    parameter int HEAP_WORDS   = HEAP_WORDS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [10:0] s_request_size,
    input  wire logic [9:0]  s_block_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [9:0]       m_granted_address,
    output logic [10:0]      m_granted_size,
    output logic [6:0]       m_reclaimed_count
);
    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SZW = $clog2(HEAP_WORDS + 1);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int EW = AW + SZW + 2;

    logic          idle, done, ack, sel, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data_a, rd_data_b, wr_data;
    result_t       result;
    result_t       out_reg;
    logic          m_valid_reg;

    assign s_ready = idle;
    assign ack     = done && (!m_valid_reg || m_ready);

    ffams_walk #(
        .HEAP_WORDS   (HEAP_WORDS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_valid && idle),
        .mode          (s_mode),
        .request_size  (s_request_size),
        .block_address (s_block_address),
        .idle          (idle),
        .done          (done),
        .ack           (ack),
        .result        (result),
        .sel           (sel),
        .rd_addr       (rd_addr),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    ffams_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram_a (
        .aclk  (aclk),
        .we    (wr_en && sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data_a)
    );

    ffams_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram_b (
        .aclk  (aclk),
        .we    (wr_en && !sel),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            out_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_granted_address = out_reg.granted_address;
    assign m_granted_size    = out_reg.granted_size;
    assign m_reclaimed_count = out_reg.reclaimed_count;
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the first-fit heap allocator with mark and sweep.
`default_nettype none
module tb;
    import ffams_pkg::*;

    localparam int HEAP = HEAP_WORDS_DEF;
    localparam int NSEG = MAX_SEGMENTS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] request_size;
        logic [9:0]  block_address;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = MODE_ALLOC;
    logic [10:0] s_request_size = '0;
    logic [9:0] s_block_address = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic [9:0] m_granted_address;
    logic [10:0] m_granted_size;
    logic [6:0] m_reclaimed_count;

    first_fit_allocator_mark_sweep_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_request_size(s_request_size), .s_block_address(s_block_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_address(m_granted_address), .m_granted_size(m_granted_size),
        .m_reclaimed_count(m_reclaimed_count)
    );

    // Heap segment table kept by the predictor.
    int unsigned seg_start[NSEG];
    int unsigned seg_size[NSEG];
    bit seg_free[NSEG];
    bit seg_marked[NSEG];
    int unsigned seg_count;

    request_t pending_requests[$];
    result_t expected_results[$];
    int unsigned live_blocks[$];
    bit drain_hold = 1'b0;
    bit long_stall = 1'b0;
    bit failed = 1'b0;
    bit finished = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic void heap_reset();
        for (int i = 0; i < NSEG; i++) begin
            seg_start[i] = 0;
            seg_size[i] = 0;
            seg_free[i] = 0;
            seg_marked[i] = 0;
        end
        seg_size[0] = HEAP;
        seg_free[0] = 1;
        seg_count = 1;
    endfunction

    function automatic void remove_segment(int unsigned idx);
        for (int unsigned k = idx; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k + 1];
            seg_size[k] = seg_size[k + 1];
            seg_free[k] = seg_free[k + 1];
            seg_marked[k] = seg_marked[k + 1];
        end
        seg_count--;
        seg_start[seg_count] = 0;
        seg_size[seg_count] = 0;
        seg_free[seg_count] = 0;
        seg_marked[seg_count] = 0;
    endfunction

    function automatic void coalesce();
        int unsigned i;
        i = 0;
        while (i + 1 < seg_count) begin
            if (seg_free[i] && seg_free[i + 1]) begin
                seg_size[i] += seg_size[i + 1];
                remove_segment(i + 1);
            end else begin
                i++;
            end
        end
    endfunction

    function automatic int find_block(int unsigned addr);
        for (int i = 0; i < seg_count; i++)
            if (seg_start[i] == addr && !seg_free[i]) return i;
        return -1;
    endfunction

    function automatic result_t heap_step(request_t rq);
        result_t r;
        int idx;
        int unsigned n;
        bit done;
        r = '0;
        r.status = STAT_OK;
        case (rq.mode)
            MODE_ALLOC: begin
                if (rq.request_size == 0) begin
                    r.status = STAT_BAD_SIZE;
                end else begin
                    r.status = STAT_NO_FIT;
                    done = 0;
                    for (int unsigned i = 0; i < seg_count && !done; i++) begin
                        if (seg_free[i] && seg_size[i] >= rq.request_size) begin
                            done = 1;
                            if (seg_size[i] != rq.request_size && seg_count >= NSEG) begin
                                r.status = STAT_FULL;
                            end else begin
                                if (seg_size[i] != rq.request_size) begin
                                    for (int unsigned k = seg_count; k > i + 1; k--) begin
                                        seg_start[k] = seg_start[k - 1];
                                        seg_size[k] = seg_size[k - 1];
                                        seg_free[k] = seg_free[k - 1];
                                        seg_marked[k] = seg_marked[k - 1];
                                    end
                                    seg_start[i + 1] = seg_start[i] + rq.request_size;
                                    seg_size[i + 1] = seg_size[i] - rq.request_size;
                                    seg_free[i + 1] = 1;
                                    seg_marked[i + 1] = 0;
                                    seg_size[i] = rq.request_size;
                                    seg_count++;
                                end
                                seg_free[i] = 0;
                                seg_marked[i] = 0;
                                r.status = STAT_OK;
                                r.granted_address = seg_start[i][9:0];
                                r.granted_size = seg_size[i][10:0];
                            end
                        end
                    end
                end
            end
            MODE_FREE: begin
                idx = find_block(rq.block_address);
                if (idx < 0) begin
                    r.status = STAT_NO_BLOCK;
                end else begin
                    seg_free[idx] = 1;
                    seg_marked[idx] = 0;
                    coalesce();
                end
            end
            MODE_MARK: begin
                idx = find_block(rq.block_address);
                if (idx < 0) r.status = STAT_NO_BLOCK;
                else seg_marked[idx] = 1;
            end
            default: begin
                n = 0;
                for (int unsigned i = 0; i < seg_count; i++) begin
                    if (!seg_free[i] && !seg_marked[i]) begin
                        seg_free[i] = 1;
                        n++;
                    end
                    seg_marked[i] = 0;
                end
                coalesce();
                r.reclaimed_count = (n > 127) ? 7'd127 : n[6:0];
            end
        endcase
        return r;
    endfunction

    // Addresses of blocks currently allocated, used to aim free and mark requests.
    function automatic void refresh_live_blocks();
        live_blocks.delete();
        for (int i = 0; i < seg_count; i++)
            if (!seg_free[i]) live_blocks.push_back(seg_start[i]);
    endfunction

    function automatic request_t make_request(logic [1:0] m, int unsigned sz, int unsigned addr);
        request_t rq;
        rq.mode = m;
        rq.request_size = sz[10:0];
        rq.block_address = addr[9:0];
        return rq;
    endfunction

    // Driver: the predictor runs on each accepted request.
    int send_gap = 0;
    request_t cur_req;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(heap_step(cur_req));
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0 || drain_hold || pending_requests.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    cur_req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= cur_req.mode;
                    s_request_size <= cur_req.request_size;
                    s_block_address <= cur_req.block_address;
                end
            end
        end
    end

    // Monitor and result checker, with the long receiver hold-off.
    int recv_gap = 0;
    int hold_cycles = 0;
    result_t got;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_status, m_granted_address, m_granted_size, m_reclaimed_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    failed = 1'b1;
                end else begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (want.status !== got.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (want.granted_address !== got.granted_address)
                        $display("%0t: granted_address expected %0d actual %0d",
                                 $time, want.granted_address, got.granted_address);
                    if (want.granted_size !== got.granted_size)
                        $display("%0t: granted_size expected %0d actual %0d",
                                 $time, want.granted_size, got.granted_size);
                    if (want.reclaimed_count !== got.reclaimed_count)
                        $display("%0t: reclaimed_count expected %0d actual %0d",
                                 $time, want.reclaimed_count, got.reclaimed_count);
                    if (want !== got) failed = 1'b1;
                end
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (long_stall && hold_cycles < 1500) begin
                hold_cycles++;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted request or result.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!finished) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Builds one random request stream; the predictor table is replayed separately
    // at acceptance, so stimulus aims at a rough shadow of the heap.
    initial begin
        int unsigned addr;
        heap_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening.
        pending_requests.push_back(make_request(MODE_ALLOC, 0, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 2047, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 1025, 0));
        pending_requests.push_back(make_request(MODE_FREE, 0, 1023));
        pending_requests.push_back(make_request(MODE_MARK, 0, 0));
        pending_requests.push_back(make_request(MODE_SWEEP, 0, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 1024, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        pending_requests.push_back(make_request(MODE_MARK, 0, 0));
        pending_requests.push_back(make_request(MODE_MARK, 0, 0));
        pending_requests.push_back(make_request(MODE_FREE, 0, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        pending_requests.push_back(make_request(MODE_MARK, 0, 0));
        pending_requests.push_back(make_request(MODE_FREE, 0, 0));
        pending_requests.push_back(make_request(MODE_SWEEP, 0, 0));
        // Fill the table with 63 one-word blocks, then hit the full table.
        for (int i = 0; i < 63; i++)
            pending_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        pending_requests.push_back(make_request(MODE_ALLOC, 5, 0));
        pending_requests.push_back(make_request(MODE_FREE, 0, 10));
        pending_requests.push_back(make_request(MODE_ALLOC, 1, 0));
        pending_requests.push_back(make_request(MODE_MARK, 0, 62));
        pending_requests.push_back(make_request(MODE_SWEEP, 0, 0));

        // Long receiver hold-off while the sender keeps offering.
        wait (pending_requests.size() < 40);
        long_stall = 1'b1;

        for (int phase = 0; phase < 30; phase++) begin
            wait (pending_requests.size() == 0 && s_valid == 1'b0);
            if (phase == 10) begin
                // Sender pauses until every result is back.
                drain_hold = 1'b1;
                wait (expected_results.size() == 0);
                drain_hold = 1'b0;
            end
            refresh_live_blocks();
            for (int j = 0; j < 50; j++) begin
                int unsigned pick;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    pending_requests.push_back(make_request(MODE_ALLOC,
                        ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(1, 40), 0));
                end else if (pick < 80 && live_blocks.size() > 0) begin
                    addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                    pending_requests.push_back(make_request(
                        ($urandom_range(0, 1) == 0) ? MODE_FREE : MODE_MARK, 0, addr));
                end else if (pick < 90) begin
                    pending_requests.push_back(make_request(
                        ($urandom_range(0, 1) == 0) ? MODE_FREE : MODE_MARK,
                        $urandom_range(0, 2047), $urandom_range(0, 1023)));
                end else begin
                    pending_requests.push_back(make_request(MODE_SWEEP,
                        $urandom_range(0, 2047), $urandom_range(0, 1023)));
                end
            end
        end
        wait (pending_requests.size() == 0 && s_valid == 1'b0);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        finished = 1'b1;
        if (!failed && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
